// ===== sv/gjc_pkg.sv =====
// Package for the grapheme join classifier: jamo class and state codes, the
// emoji base list and the byte-level decode and classify functions.
// No dependencies.
package gjc_pkg;

   // Longest previous cell taken as real data; longer ones count as empty
   localparam int unsigned MAX_CELL_BYTES = 32;
   localparam logic [7:0]  MaxCellBytes   = 8'(MAX_CELL_BYTES);

   // Code point ranges
   localparam logic [20:0] RegionalFirst = 21'h1F1E6;
   localparam logic [20:0] RegionalLast  = 21'h1F1FF;
   localparam logic [20:0] ToneFirst     = 21'h1F3FB;
   localparam logic [20:0] ToneLast      = 21'h1F3FF;

   // Exact three-byte sequences
   localparam logic [23:0] SeqJoiner   = 24'hE2808D;
   localparam logic [23:0] SeqSelector = 24'hEFB88F;
   localparam logic [23:0] SeqFiller   = 24'hE385A4;

   // Jamo lead bytes
   localparam logic [7:0] LeadJamo    = 8'hE1;
   localparam logic [7:0] LeadExtA    = 8'hEA;
   localparam logic [7:0] LeadExtB    = 8'hED;

   typedef enum logic [1:0] {
      JC_NONE = 2'd0,
      JC_INIT = 2'd1,
      JC_MED  = 2'd2,
      JC_FIN  = 2'd3
   } jamo_class_type;

   // Output state codes
   localparam logic [1:0] JS_NONE     = 2'd0;
   localparam logic [1:0] JS_INITIAL  = 2'd1;
   localparam logic [1:0] JS_COMPOSE  = 2'd2;
   localparam logic [1:0] JS_NOCOMP   = 2'd3;

   localparam int unsigned NumBases = 71;
   localparam logic [20:0] EmojiBases [NumBases] = '{
      21'h1F44B, 21'h1F44C, 21'h1F44D, 21'h1F44E, 21'h1F44F, 21'h1F450, 21'h1F466,
      21'h1F467, 21'h1F468, 21'h1F469, 21'h1F46E, 21'h1F470, 21'h1F471, 21'h1F472,
      21'h1F473, 21'h1F474, 21'h1F475, 21'h1F476, 21'h1F477, 21'h1F478, 21'h1F47C,
      21'h1F481, 21'h1F482, 21'h1F485, 21'h1F486, 21'h1F487, 21'h1F4AA, 21'h1F575,
      21'h1F57A, 21'h1F590, 21'h1F595, 21'h1F596, 21'h1F645, 21'h1F646, 21'h1F647,
      21'h1F64B, 21'h1F64C, 21'h1F64D, 21'h1F64E, 21'h1F64F, 21'h1F6B4, 21'h1F6B5,
      21'h1F6B6, 21'h1F926, 21'h1F937, 21'h1F938, 21'h1F939, 21'h1F93D, 21'h1F93E,
      21'h1F9B5, 21'h1F9B6, 21'h1F9B8, 21'h1F9B9, 21'h1F9CD, 21'h1F9CE, 21'h1F9CF,
      21'h1F9D1, 21'h1F9D2, 21'h1F9D3, 21'h1F9D4, 21'h1F9D5, 21'h1F9D6, 21'h1F9D7,
      21'h1F9D8, 21'h1F9D9, 21'h1F9DA, 21'h1F9DB, 21'h1F9DC, 21'h1F9DD, 21'h1F9DE,
      21'h1F9DF
   };

   // Well-formed four-byte sequence: lead 11110xxx, three continuations
   function automatic logic is_utf8_four(input logic [31:0] b);
      return (b & 32'hF8C0C0C0) == 32'hF0808080;
   endfunction

   function automatic logic [20:0] code_point(input logic [31:0] b);
      return {b[26:24], b[21:16], b[13:8], b[5:0]};
   endfunction

   function automatic logic is_regional(input logic [20:0] cp);
      return cp >= RegionalFirst && cp <= RegionalLast;
   endfunction

   function automatic logic is_tone(input logic [20:0] cp);
      return cp >= ToneFirst && cp <= ToneLast;
   endfunction

   // Parallel compare against every listed base
   function automatic logic is_emoji_base(input logic [20:0] cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NumBases; i++) begin
         hit = hit | (EmojiBases[i] == cp);
      end
      return hit;
   endfunction

   function automatic jamo_class_type jamo_class(input logic [23:0] v);
      logic [7:0] b0, b1, b2;
      jamo_class_type jc;
      b0 = v[23:16];
      b1 = v[15:8];
      b2 = v[7:0];
      jc = JC_NONE;
      if (b0 == LeadJamo) begin
         if (b1 == 8'h84 && b2 >= 8'h80 && b2 <= 8'hBF)      jc = JC_INIT;
         else if (b1 == 8'h85 && b2 >= 8'h80 && b2 <= 8'h9F) jc = JC_INIT;
         else if (b1 == 8'h85 && b2 >= 8'hA0 && b2 <= 8'hBF) jc = JC_MED;
         else if (b1 == 8'h86 && b2 >= 8'h80 && b2 <= 8'hA7) jc = JC_MED;
         else if (b1 == 8'h86 && b2 >= 8'hA8 && b2 <= 8'hBF) jc = JC_FIN;
         else if (b1 == 8'h87 && b2 >= 8'h80 && b2 <= 8'hBF) jc = JC_FIN;
      end else if (b0 == LeadExtA) begin
         if (b1 == 8'hA5 && b2 >= 8'hA0 && b2 <= 8'hBC)      jc = JC_INIT;
      end else if (b0 == LeadExtB) begin
         if (b1 == 8'h9E && b2 >= 8'hB0 && b2 <= 8'hBF)      jc = JC_MED;
         else if (b1 == 8'h9F && b2 >= 8'h80 && b2 <= 8'h86) jc = JC_MED;
         else if (b1 == 8'h9F && b2 >= 8'h8B && b2 <= 8'hBB) jc = JC_FIN;
      end
      return jc;
   endfunction

endpackage

// ===== sv/grapheme_join_classifier_top.sv =====
// Top level of the grapheme join classifier: input register, classify logic
// and result register. Depends on gjc_pkg.
//
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------------------------
//  request   | start / busy       | req_prev_len, req_prev_tail, req_new_len,
//            |                    | req_new_bytes
//  response  | rsp_valid (strobe) | rsp_should_join, rsp_prev_ends_joiner,
//            |                    | rsp_new_is_joiner, rsp_new_is_selector,
//            |                    | rsp_new_is_filler, rsp_jamo_state
//
// One beat per cycle; a response appears after its request beat has passed
// the input register and then the result register. busy is always low: the
// classify logic between the two registers is combinational and holds no state.
// Synchronous reset clears both valid flags only. The receiver cannot stall,
// so every response is shown for exactly one cycle.
module grapheme_join_classifier_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [5:0]  req_prev_len,
   input  logic [31:0] req_prev_tail,
   input  logic [5:0]  req_new_len,
   input  logic [31:0] req_new_bytes,
   output logic        rsp_valid,
   output logic        rsp_should_join,
   output logic        rsp_prev_ends_joiner,
   output logic        rsp_new_is_joiner,
   output logic        rsp_new_is_selector,
   output logic        rsp_new_is_filler,
   output logic [1:0]  rsp_jamo_state
);
   import gjc_pkg::*;

   logic        in_valid_ff;
   logic [5:0]  prev_len_ff, new_len_ff;
   logic [31:0] prev_tail_ff, new_bytes_ff;

   logic        rsp_valid_ff;
   logic        join_ff, pzwj_ff, nzwj_ff, nvs_ff, nfill_ff;
   logic [1:0]  state_ff;

   logic        join_in, pzwj_in, nzwj_in, nvs_in, nfill_in;
   logic [1:0]  state_in;

   logic        accept;
   logic        prev_ok, prev_ge3, prev_four, new_four, new_three;
   logic [20:0] prev_cp, new_cp;
   jamo_class_type nc, pc;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Request beat capture
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_len_ff  <= req_prev_len;
         prev_tail_ff <= req_prev_tail;
         new_len_ff   <= req_new_len;
         new_bytes_ff <= req_new_bytes;
      end
   end

   // Cell length qualifiers; an oversized previous cell counts as empty
   always_comb begin
      prev_ok   = {2'b00, prev_len_ff} <= MaxCellBytes;
      prev_ge3  = prev_ok && prev_len_ff >= 6'd3;
      prev_four = prev_ok && prev_len_ff == 6'd4 && is_utf8_four(prev_tail_ff);
      new_four  = new_len_ff == 6'd4 && is_utf8_four(new_bytes_ff);
      new_three = new_len_ff == 6'd3;
      prev_cp   = code_point(prev_tail_ff);
      new_cp    = code_point(new_bytes_ff);
   end

   // Join test and exact-match flags
   always_comb begin
      join_in = prev_four && new_four &&
                ((is_regional(prev_cp) && is_regional(new_cp)) ||
                 (is_emoji_base(prev_cp) && is_tone(new_cp)));
      pzwj_in  = prev_ge3 && prev_tail_ff[23:0] == SeqJoiner;
      nzwj_in  = new_three && new_bytes_ff[23:0] == SeqJoiner;
      nvs_in   = new_three && new_bytes_ff[23:0] == SeqSelector;
      nfill_in = new_three && new_bytes_ff[23:0] == SeqFiller;
   end

   // Jamo composition state
   always_comb begin
      nc       = jamo_class(new_bytes_ff[23:0]);
      pc       = prev_ge3 ? jamo_class(prev_tail_ff[23:0]) : JC_NONE;
      state_in = JS_NONE;
      if (new_three) begin
         unique case (nc)
            JC_INIT: state_in = JS_INITIAL;
            JC_MED:  state_in = (pc == JC_INIT) ? JS_COMPOSE : JS_NOCOMP;
            JC_FIN:  state_in = (pc == JC_MED)  ? JS_COMPOSE : JS_NOCOMP;
            default: state_in = JS_NONE;
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         join_ff  <= join_in;
         pzwj_ff  <= pzwj_in;
         nzwj_ff  <= nzwj_in;
         nvs_ff   <= nvs_in;
         nfill_ff <= nfill_in;
         state_ff <= state_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_should_join      = join_ff;
   assign rsp_prev_ends_joiner = pzwj_ff;
   assign rsp_new_is_joiner    = nzwj_ff;
   assign rsp_new_is_selector  = nvs_ff;
   assign rsp_new_is_filler    = nfill_ff;
   assign rsp_jamo_state       = state_ff;

`ifndef ASSERT_OFF
   // Every request beat gives a response once it has passed both registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("request beat lost");

   // No response without a captured request
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_valid_ff))
      else $error("response without request");

   // The three exact sequences cannot match together
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_new_is_joiner, rsp_new_is_selector, rsp_new_is_filler}))
      else $error("exact-match flags overlap");

   // A join needs four-byte characters, a jamo state and a joiner tail three-byte ones
   a_join_jamo: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_should_join) |-> (rsp_jamo_state == JS_NONE && !rsp_prev_ends_joiner))
      else $error("join with three-byte result");
`endif

endmodule

// ===== tb/grapheme_join_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the grapheme join classifier: watches the request and response
// channels, predicts each response from its request beat and compares them.
// Depends on gjc_pkg for the jamo class enum, the jamo state codes and MAX_CELL_BYTES.
module grapheme_join_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [5:0]  req_prev_len,
   input  logic [31:0] req_prev_tail,
   input  logic [5:0]  req_new_len,
   input  logic [31:0] req_new_bytes,
   input  logic        rsp_valid,
   input  logic        rsp_should_join,
   input  logic        rsp_prev_ends_joiner,
   input  logic        rsp_new_is_joiner,
   input  logic        rsp_new_is_selector,
   input  logic        rsp_new_is_filler,
   input  logic [1:0]  rsp_jamo_state,
   output int          mismatches,
   output int          outstanding
);
   import gjc_pkg::*;

   typedef struct packed {
      logic       should_join;
      logic       prev_ends_joiner;
      logic       new_is_joiner;
      logic       new_is_selector;
      logic       new_is_filler;
      logic [1:0] jamo_state;
   } pair_verdict_type;

   localparam int unsigned BaseCount = 71;

   // Emoji bases that take a skin tone modifier
   localparam logic [20:0] ToneBases [BaseCount] = '{
      21'h1F44B, 21'h1F44C, 21'h1F44D, 21'h1F44E, 21'h1F44F, 21'h1F450, 21'h1F466,
      21'h1F467, 21'h1F468, 21'h1F469, 21'h1F46E, 21'h1F470, 21'h1F471, 21'h1F472,
      21'h1F473, 21'h1F474, 21'h1F475, 21'h1F476, 21'h1F477, 21'h1F478, 21'h1F47C,
      21'h1F481, 21'h1F482, 21'h1F485, 21'h1F486, 21'h1F487, 21'h1F4AA, 21'h1F575,
      21'h1F57A, 21'h1F590, 21'h1F595, 21'h1F596, 21'h1F645, 21'h1F646, 21'h1F647,
      21'h1F64B, 21'h1F64C, 21'h1F64D, 21'h1F64E, 21'h1F64F, 21'h1F6B4, 21'h1F6B5,
      21'h1F6B6, 21'h1F926, 21'h1F937, 21'h1F938, 21'h1F939, 21'h1F93D, 21'h1F93E,
      21'h1F9B5, 21'h1F9B6, 21'h1F9B8, 21'h1F9B9, 21'h1F9CD, 21'h1F9CE, 21'h1F9CF,
      21'h1F9D1, 21'h1F9D2, 21'h1F9D3, 21'h1F9D4, 21'h1F9D5, 21'h1F9D6, 21'h1F9D7,
      21'h1F9D8, 21'h1F9D9, 21'h1F9DA, 21'h1F9DB, 21'h1F9DC, 21'h1F9DD, 21'h1F9DE,
      21'h1F9DF
   };

   pair_verdict_type pending_verdicts [$];

   // {well formed, code point} of a cell that must hold one four-byte character
   function automatic logic [21:0] decode_cell(input logic [5:0] len, input logic [31:0] b);
      logic ok;
      ok = (len == 6'd4) && (b[31:27] == 5'b11110) && (b[23:22] == 2'b10) &&
           (b[15:14] == 2'b10) && (b[7:6] == 2'b10);
      return {ok, b[26:24], b[21:16], b[13:8], b[5:0]};
   endfunction

   function automatic logic takes_tone(input logic [20:0] cp);
      logic hit;
      hit = 1'b0;
      foreach (ToneBases[i]) if (ToneBases[i] == cp) hit = 1'b1;
      return hit;
   endfunction

   // Jamo class by 24-bit byte ranges
   function automatic jamo_class_type classify_jamo(input logic [23:0] v);
      jamo_class_type jc;
      jc = JC_NONE;
      if ((v >= 24'hE18480 && v <= 24'hE184BF) || (v >= 24'hE18580 && v <= 24'hE1859F) ||
          (v >= 24'hEAA5A0 && v <= 24'hEAA5BC))
         jc = JC_INIT;
      else if ((v >= 24'hE185A0 && v <= 24'hE185BF) || (v >= 24'hE18680 && v <= 24'hE186A7) ||
               (v >= 24'hED9EB0 && v <= 24'hED9EBF) || (v >= 24'hED9F80 && v <= 24'hED9F86))
         jc = JC_MED;
      else if ((v >= 24'hE186A8 && v <= 24'hE186BF) || (v >= 24'hE18780 && v <= 24'hE187BF) ||
               (v >= 24'hED9F8B && v <= 24'hED9FBB))
         jc = JC_FIN;
      return jc;
   endfunction

   function automatic pair_verdict_type classify_pair(input logic [5:0] plen_in,
                                                      input logic [31:0] ptail,
                                                      input logic [5:0] nlen,
                                                      input logic [31:0] nbytes);
      pair_verdict_type v;
      logic [5:0] plen;
      logic [21:0] pcell, ncell;
      logic prev_long;
      jamo_class_type nc, pc;
      v = '0;
      // an oversized previous cell counts as empty
      plen = (plen_in > 6'(MAX_CELL_BYTES)) ? 6'd0 : plen_in;
      prev_long = plen >= 6'd3;
      pcell = decode_cell(plen, ptail);
      ncell = decode_cell(nlen, nbytes);
      if (pcell[21] && ncell[21]) begin
         if (pcell[20:0] >= 21'h1F1E6 && pcell[20:0] <= 21'h1F1FF &&
             ncell[20:0] >= 21'h1F1E6 && ncell[20:0] <= 21'h1F1FF)
            v.should_join = 1'b1;
         else if (takes_tone(pcell[20:0]) && ncell[20:0] >= 21'h1F3FB &&
                  ncell[20:0] <= 21'h1F3FF)
            v.should_join = 1'b1;
      end
      v.prev_ends_joiner = prev_long && ptail[23:0] == 24'hE2808D;
      if (nlen == 6'd3) begin
         v.new_is_joiner   = nbytes[23:0] == 24'hE2808D;
         v.new_is_selector = nbytes[23:0] == 24'hEFB88F;
         v.new_is_filler   = nbytes[23:0] == 24'hE385A4;
         nc = classify_jamo(nbytes[23:0]);
         pc = prev_long ? classify_jamo(ptail[23:0]) : JC_NONE;
         case (nc)
            JC_INIT: v.jamo_state = JS_INITIAL;
            JC_MED:  v.jamo_state = (pc == JC_INIT) ? JS_COMPOSE : JS_NOCOMP;
            JC_FIN:  v.jamo_state = (pc == JC_MED) ? JS_COMPOSE : JS_NOCOMP;
            default: v.jamo_state = JS_NONE;
         endcase
      end
      return v;
   endfunction

   // Queue a prediction per request beat, compare each response beat
   always @(posedge clock) begin
      pair_verdict_type seen, want;
      if (reset) begin
         pending_verdicts.delete();
         mismatches = 0;
      end else begin
         if (start && !busy)
            pending_verdicts.push_back(classify_pair(req_prev_len, req_prev_tail,
                                                     req_new_len, req_new_bytes));
         if (rsp_valid) begin
            seen = {rsp_should_join, rsp_prev_ends_joiner, rsp_new_is_joiner,
                    rsp_new_is_selector, rsp_new_is_filler, rsp_jamo_state};
            if (pending_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response beat with nothing outstanding: %b", $time, seen);
            end else begin
               want = pending_verdicts.pop_front();
               if (seen !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $write("%0t: mismatch join %b/%b zwj_prev %b/%b zwj %b/%b ",
                            $time, want.should_join, seen.should_join,
                            want.prev_ends_joiner, seen.prev_ends_joiner,
                            want.new_is_joiner, seen.new_is_joiner);
                     $display("vs16 %b/%b filler %b/%b jamo %0d/%0d (exp/got)",
                              want.new_is_selector, seen.new_is_selector,
                              want.new_is_filler, seen.new_is_filler,
                              want.jamo_state, seen.jamo_state);
                  end
               end
            end
         end
      end
      outstanding = pending_verdicts.size();
   end

endmodule

// ===== tb/tb_grapheme_join_classifier_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the grapheme join classifier: clock, reset, request beats
// (directed, then random pairs) and the final verdict.
// Depends on gjc_pkg, grapheme_join_classifier_top and grapheme_join_checker.
module tb_grapheme_join_classifier_top;
   import gjc_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [5:0]  req_prev_len;
   logic [31:0] req_prev_tail;
   logic [5:0]  req_new_len;
   logic [31:0] req_new_bytes;
   logic        rsp_valid;
   logic        rsp_should_join;
   logic        rsp_prev_ends_joiner;
   logic        rsp_new_is_joiner;
   logic        rsp_new_is_selector;
   logic        rsp_new_is_filler;
   logic [1:0]  rsp_jamo_state;
   int          mismatches;
   int          outstanding;
   bit          allow_idle;

   always #5 clock = ~clock;

   grapheme_join_classifier_top DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_prev_len         (req_prev_len),
      .req_prev_tail        (req_prev_tail),
      .req_new_len          (req_new_len),
      .req_new_bytes        (req_new_bytes),
      .rsp_valid            (rsp_valid),
      .rsp_should_join      (rsp_should_join),
      .rsp_prev_ends_joiner (rsp_prev_ends_joiner),
      .rsp_new_is_joiner    (rsp_new_is_joiner),
      .rsp_new_is_selector  (rsp_new_is_selector),
      .rsp_new_is_filler    (rsp_new_is_filler),
      .rsp_jamo_state       (rsp_jamo_state)
   );

   grapheme_join_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_prev_len         (req_prev_len),
      .req_prev_tail        (req_prev_tail),
      .req_new_len          (req_new_len),
      .req_new_bytes        (req_new_bytes),
      .rsp_valid            (rsp_valid),
      .rsp_should_join      (rsp_should_join),
      .rsp_prev_ends_joiner (rsp_prev_ends_joiner),
      .rsp_new_is_joiner    (rsp_new_is_joiner),
      .rsp_new_is_selector  (rsp_new_is_selector),
      .rsp_new_is_filler    (rsp_new_is_filler),
      .rsp_jamo_state       (rsp_jamo_state),
      .mismatches           (mismatches),
      .outstanding          (outstanding)
   );

   // Watchdog
   initial begin
      #5_000_000;
      $display("[grapheme_join_classifier_top] ERROR");
      $finish;
   end

   function automatic logic [31:0] utf8_four(input logic [20:0] cp);
      return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
   endfunction

   // Regional indicators, one either side of the range included
   function automatic logic [20:0] regional_cp();
      return RegionalFirst - 21'd1 + 21'($urandom_range(0, 27));
   endfunction

   function automatic logic [20:0] tone_cp();
      return ToneFirst - 21'd1 + 21'($urandom_range(0, 6));
   endfunction

   // Listed base, now and then a neighbour
   function automatic logic [20:0] base_cp();
      logic [20:0] cp;
      cp = EmojiBases[$urandom_range(0, NumBases - 1)];
      case ($urandom_range(0, 7))
         0:       cp = cp + 21'd1;
         1:       cp = cp - 21'd1;
         default: ;
      endcase
      return cp;
   endfunction

   // Three bytes around the jamo ranges, boundaries included
   function automatic logic [23:0] jamo_bytes();
      logic [7:0] lead, mid, low;
      case ($urandom_range(0, 2))
         0: begin
            lead = LeadJamo;
            mid  = 8'h83 + 8'($urandom_range(0, 5));
         end
         1: begin
            lead = LeadExtA;
            mid  = 8'hA4 + 8'($urandom_range(0, 2));
         end
         default: begin
            lead = LeadExtB;
            mid  = 8'h9D + 8'($urandom_range(0, 3));
         end
      endcase
      low = 8'h7F + 8'($urandom_range(0, 65));
      return {lead, mid, low};
   endfunction

   // Exact sequences or a one-bit miss of one
   function automatic logic [23:0] special_bytes();
      logic [23:0] s;
      case ($urandom_range(0, 2))
         0:       s = SeqJoiner;
         1:       s = SeqSelector;
         default: s = SeqFiller;
      endcase
      if ($urandom_range(0, 3) == 0) s[$urandom_range(0, 23)] ^= 1'b1;
      return s;
   endfunction

   // Mostly well-formed pairs of one kind, the rest noise and damaged beats
   task automatic make_pair(output logic [5:0] pl, output logic [31:0] pt,
                            output logic [5:0] nl, output logic [31:0] nb);
      pl = 6'd4;
      nl = 6'd4;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            pt = utf8_four(regional_cp());
            nb = utf8_four(regional_cp());
         end
         3, 4: begin
            pt = utf8_four(base_cp());
            nb = utf8_four(tone_cp());
         end
         5, 6: begin
            pt = {8'($urandom), jamo_bytes()};
            nb = {8'($urandom), jamo_bytes()};
            pl = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 40)) : 6'd3;
            nl = 6'd3;
         end
         7: begin
            pt = {8'($urandom), ($urandom_range(0, 1) == 0) ? SeqJoiner : jamo_bytes()};
            nb = {8'($urandom), special_bytes()};
            pl = 6'($urandom_range(0, 40));
            nl = 6'd3;
         end
         default: begin
            pt = $urandom;
            nb = ($urandom_range(0, 1) == 0) ? utf8_four(21'($urandom)) : $urandom;
            pl = 6'($urandom_range(0, 63));
            nl = 6'($urandom_range(0, 63));
         end
      endcase
      // damage
      if ($urandom_range(0, 7) == 0) pt[$urandom_range(0, 31)] ^= 1'b1;
      if ($urandom_range(0, 7) == 0) nb[$urandom_range(0, 31)] ^= 1'b1;
      if ($urandom_range(0, 7) == 0) pl = 6'($urandom_range(0, 63));
      if ($urandom_range(0, 7) == 0) nl = 6'($urandom_range(0, 63));
   endtask

   // One request beat, optionally after a short idle gap (before about 6 beats in 100)
   task automatic send_beat(input logic [5:0] pl, input logic [31:0] pt,
                            input logic [5:0] nl, input logic [31:0] nb);
      bit taken;
      if (allow_idle && $urandom_range(0, 99) < 6) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start         <= 1'b1;
      req_prev_len  <= pl;
      req_prev_tail <= pt;
      req_new_len   <= nl;
      req_new_bytes <= nb;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
   endtask

   // Hold the sender until every response is back
   task automatic drain_responses();
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   initial begin
      logic [5:0]  pl, nl;
      logic [31:0] pt, nb;
      reset         = 1'b1;
      start         = 1'b0;
      req_prev_len  = '0;
      req_prev_tail = '0;
      req_new_len   = '0;
      req_new_bytes = '0;
      allow_idle    = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // field extremes
      send_beat(6'd0,  32'h0000_0000, 6'd0,  32'h0000_0000);
      send_beat(6'd63, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
      // regional indicator pairs and range edges
      send_beat(6'd4, 32'hF09F_87A6, 6'd4, 32'hF09F_87BF);
      send_beat(6'd4, 32'hF09F_87A5, 6'd4, 32'hF09F_87A6);
      send_beat(6'd4, 32'hF09F_8880, 6'd4, 32'hF09F_87BF);
      // emoji base plus skin tone, and near misses
      send_beat(6'd4, 32'hF09F_918B, 6'd4, 32'hF09F_8FBB);
      send_beat(6'd4, 32'hF09F_A79F, 6'd4, 32'hF09F_8FBF);
      send_beat(6'd4, 32'hF09F_918A, 6'd4, 32'hF09F_8FBB);
      send_beat(6'd4, 32'hF09F_918B, 6'd4, 32'hF09F_8FBA);
      send_beat(6'd4, 32'hF09F_918B, 6'd4, 32'hF09F_9080);
      // not a single well-formed four-byte character
      send_beat(6'd3, 32'hF09F_87A6, 6'd4, 32'hF09F_87A6);
      send_beat(6'd4, 32'hF09F_87A6, 6'd5, 32'hF09F_87A6);
      send_beat(6'd4, 32'hF09F_C7A6, 6'd4, 32'hF09F_87A6);
      send_beat(6'd4, 32'hF89F_87A6, 6'd4, 32'hF09F_87A6);
      // joiner, selector, filler; short, full-size and oversized previous cell
      send_beat(6'd3,  32'h00E2_808D, 6'd3, 32'h00E2_808D);
      send_beat(6'd2,  32'h00E2_808D, 6'd3, 32'h00EF_B88F);
      send_beat(6'd32, 32'hFFE2_808D, 6'd3, 32'h00E3_85A4);
      send_beat(6'd33, 32'h00E2_808D, 6'd3, 32'h00E1_85A0);
      // jamo composition
      send_beat(6'd3, 32'h00E1_8480, 6'd3, 32'h00E1_85A0);
      send_beat(6'd2, 32'h00E1_8480, 6'd3, 32'h00E1_85A0);
      send_beat(6'd3, 32'h00E1_85BF, 6'd3, 32'h00E1_86A8);
      send_beat(6'd3, 32'h00E1_8480, 6'd3, 32'h00ED_9FBB);
      send_beat(6'd5, 32'h12EA_A5BC, 6'd3, 32'h00EA_A5A0);
      send_beat(6'd3, 32'h00ED_9F86, 6'd3, 32'h00ED_9F8B);
      send_beat(6'd3, 32'h00E1_8480, 6'd3, 32'h00ED_9F87);
      // new character not three bytes long
      send_beat(6'd3, 32'h00E2_808D, 6'd4, 32'h00E2_808D);
      drain_responses();

      // random pairs, with a stretch at full rate
      for (int item = 0; item < 1050; item++) begin
         allow_idle = !(item >= 300 && item < 550);
         if (item == 700) drain_responses();
         make_pair(pl, pt, nl, nb);
         send_beat(pl, pt, nl, nb);
      end

      drain_responses();
      repeat (4) @(posedge clock);
      @(negedge clock);
      if (mismatches == 0)
         $display("[grapheme_join_classifier_top] OK");
      else
         $display("[grapheme_join_classifier_top] ERROR");
      $finish;
   end

endmodule
